/* hdl/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/cfa_pkg.sv */
// Types and constants of the contiguous fit allocator.
`timescale 1ns / 1ps
package cfa_pkg;
	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_FREE    = 3'd1;
	localparam logic [2:0] MODE_COMPACT = 3'd2;
	localparam logic [2:0] MODE_CLEAR   = 3'd3;
	localparam logic [2:0] MODE_READ    = 3'd4;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
	localparam logic [2:0] ST_NO_FIT     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [2:0] ST_NOT_LETTER = 3'd4;

	localparam logic [7:0] FREE_CELL = 8'd46;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] owner;
		logic [8:0] request_size;
		logic [1:0] fit_policy;
		logic [7:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] start_index;
		logic [7:0] read_owner;
	} rsp_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction
endpackage

/* hdl/cfa_cell_ram.sv */
// Single-port-write, one-read synchronous cell memory.
`timescale 1ns / 1ps
module cfa_cell_ram #(
	parameter int CELLS = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/cfa_seq.sv */
// Command sequencer: scans, writes and compacts the cell memory.
`timescale 1ns / 1ps
module cfa_seq
	import cfa_pkg::*;
#(
	parameter int CELLS = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic          cmd_go,
	output logic          busy,
	output logic          rsp_done,
	output rsp_t          rsp,
	output logic          we,
	output logic [AW-1:0] waddr,
	output logic [7:0]    wdata,
	output logic [AW-1:0] raddr,
	input  logic [7:0]    rdata
);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] NCELLS = CW'(CELLS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_TAIL  = 3'd4;
	localparam logic [2:0] S_READ  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]    state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] rd_q;      // next read address
	logic [CW-1:0] pos_s1;    // address whose data arrives this cycle
	logic          vld_s1;
	logic [CW-1:0] run_start_q, run_len_q, pick_q, pick_len_q, wr_q, fill_end_q;
	logic          in_run_q, found_q, hit_q;
	rsp_t          rsp_q;

	// Run closing logic used during the allocate scan.
	logic          cell_free, at_end, close_run, take;
	logic [CW-1:0] run_len_nxt, cur_start;

	always_comb begin
		cell_free   = vld_s1 && rdata == FREE_CELL;
		run_len_nxt = cell_free ? (in_run_q ? run_len_q + 1'b1 : CW'(1)) : run_len_q;
		cur_start   = (cell_free && !in_run_q) ? pos_s1 : run_start_q;
		at_end      = vld_s1 && pos_s1 == NCELLS - 1'b1;
		close_run   = vld_s1 && ((!cell_free && in_run_q) || (cell_free && at_end));
		take        = 1'b0;
		if (close_run && run_len_nxt >= CW'(cmd_q.request_size)) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (cmd_q.fit_policy == FIT_BEST) begin
				take = run_len_nxt < pick_len_q;
			end else if (cmd_q.fit_policy == FIT_WORST) begin
				take = run_len_nxt > pick_len_q;
			end
		end
	end

	assign busy     = state_q != S_IDLE;
	assign rsp_done = state_q == S_DONE;
	assign rsp      = rsp_q;
	assign raddr    = rd_q[AW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = FREE_CELL;
		unique case (state_q)
			S_FILL: begin
				we    = 1'b1;
				wdata = cmd_q.owner;
			end
			S_SWEEP: begin
				if (cmd_q.mode == MODE_FREE) begin
					we    = vld_s1 && rdata == cmd_q.owner;
					waddr = pos_s1[AW-1:0];
				end else begin
					we    = vld_s1 && rdata != FREE_CELL;
					wdata = rdata;
				end
			end
			S_TAIL:  we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_go) begin
						cmd_q       <= cmd;
						rd_q        <= '0;
						vld_s1      <= 1'b0;
						in_run_q    <= 1'b0;
						found_q     <= 1'b0;
						hit_q       <= 1'b0;
						wr_q        <= '0;
						run_len_q   <= '0;
						run_start_q <= '0;
						rsp_q       <= '0;
						unique case (cmd.mode)
							MODE_ALLOC: begin
								if (!is_letter(cmd.owner)) begin
									rsp_q.status <= ST_NOT_LETTER;
									state_q      <= S_DONE;
								end else if (cmd.request_size == '0 ||
										32'(cmd.request_size) > 32'(CELLS)) begin
									rsp_q.status <= ST_BAD_SIZE;
									state_q      <= S_DONE;
								end else if (cmd.fit_policy != FIT_FIRST &&
										cmd.fit_policy != FIT_BEST &&
										cmd.fit_policy != FIT_WORST) begin
									rsp_q.status <= ST_NO_FIT;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							MODE_FREE: begin
								if (!is_letter(cmd.owner)) begin
									rsp_q.status <= ST_NOT_LETTER;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SWEEP;
								end
							end
							MODE_COMPACT: state_q <= S_SWEEP;
							MODE_CLEAR:   state_q <= S_TAIL;
							MODE_READ: begin
								if (32'(cmd.cell_index) < 32'(CELLS)) begin
									rd_q    <= CW'(cmd.cell_index);
									state_q <= S_READ;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					// One cell a cycle; read data arrives in the cycle after its address.
					vld_s1 <= rd_q < NCELLS;
					pos_s1 <= rd_q;
					if (rd_q < NCELLS) begin
						rd_q <= rd_q + 1'b1;
					end
					if (vld_s1) begin
						in_run_q    <= cell_free && !at_end;
						run_len_q   <= close_run ? '0 : run_len_nxt;
						run_start_q <= cur_start;
						if (take) begin
							found_q    <= 1'b1;
							pick_q     <= cur_start;
							pick_len_q <= run_len_nxt;
						end
					end
					if ((vld_s1 && at_end) || (take && cmd_q.fit_policy == FIT_FIRST)) begin
						vld_s1 <= 1'b0;
						if (take || found_q) begin
							wr_q        <= take ? cur_start : pick_q;
							fill_end_q  <= (take ? cur_start : pick_q) +
								CW'(cmd_q.request_size);
							rsp_q.start_index <= 8'(take ? cur_start : pick_q);
							state_q     <= S_FILL;
						end else begin
							rsp_q.status <= ST_NO_FIT;
							state_q      <= S_DONE;
						end
					end
				end
				S_FILL: begin
					wr_q <= wr_q + 1'b1;
					if (wr_q + 1'b1 == fill_end_q) begin
						state_q <= S_DONE;
					end
				end
				S_SWEEP: begin
					vld_s1 <= rd_q < NCELLS;
					pos_s1 <= rd_q;
					if (rd_q < NCELLS) begin
						rd_q <= rd_q + 1'b1;
					end
					// Compaction writes never overtake the read pointer.
					if (we) begin
						hit_q <= 1'b1;
						wr_q  <= wr_q + 1'b1;
					end
					if (vld_s1 && pos_s1 == NCELLS - 1'b1) begin
						vld_s1 <= 1'b0;
						if (cmd_q.mode == MODE_FREE) begin
							rsp_q.status <= (hit_q || we) ? ST_OK : ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else if ((we ? wr_q + 1'b1 : wr_q) == NCELLS) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_TAIL;
						end
					end
				end
				S_TAIL: begin
					wr_q <= wr_q + 1'b1;
					if (wr_q == NCELLS - 1'b1) begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					vld_s1  <= 1'b1;
					if (vld_s1) begin
						rsp_q.read_owner <= rdata;
						vld_s1           <= 1'b0;
						state_q          <= S_DONE;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hdl/contiguous_fit_allocator_top.sv */
// Top level of the contiguous fit allocator.
// Commands arrive on the in channel (in_valid, in_stall, in_data) and one
// result per command leaves on the out channel (out_valid, out_stall,
// out_data). A transfer happens at a rising edge with valid high and stall
// low. Commands are handled one at a time by a sequencer that walks the cell
// memory one cell a cycle through its single read port.
// Handling: allocate scans the memory and fills the run it picks (first
// fit ends the scan at the first run that fits), free and compact sweep the
// memory and compact then frees the tail, clear frees every cell, read
// fetches one cell, and rejected commands go straight to the result.
// The scan of the memory sets the rate: at most two passes over MEM_CELLS
// per command; the next command can be taken as soon as out_valid rises,
// when out_stall is low.
// The result sits in an output register; the next command is taken while
// it waits, and in_stall rises while the sequencer is busy or the register
// is full and stalled. Out_stall holds the result unchanged.
// After reset every cell reads free: a clearing pass over all MEM_CELLS
// cells runs first and holds in_stall high until it ends.
`timescale 1ns / 1ps
module contiguous_fit_allocator_top
	import cfa_pkg::*;
#(
	parameter int MEM_CELLS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cmd_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);
	localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;

	logic          busy, done, we;
	logic [AW-1:0] waddr, raddr, clr_q;
	logic [7:0]    wdata, rdata;
	logic          clr_busy_q, out_full_q, go;
	rsp_t          rsp, out_q;

	assign in_stall  = busy || clr_busy_q || (out_full_q && out_stall);
	assign go        = in_valid && !in_stall;
	assign out_valid = out_full_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(MEM_CELLS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (done) begin
				out_full_q <= 1'b1;
			end else if (!out_stall) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= rsp;
		end
	end

	cfa_seq #(.CELLS(MEM_CELLS), .AW(AW)) u_seq (
		.clk, .arst_n,
		.cmd(in_data), .cmd_go(go), .busy, .rsp_done(done), .rsp,
		.we, .waddr, .wdata, .raddr, .rdata
	);

	cfa_cell_ram #(.CELLS(MEM_CELLS), .AW(AW)) u_ram (
		.clk,
		.we(we || clr_busy_q),
		.waddr(clr_busy_q ? clr_q : waddr),
		.wdata(clr_busy_q ? FREE_CELL : wdata),
		.raddr, .rdata
	);
endmodule

/* hdl/cfa_checker.sv */
// Port checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfa_port_checker
	import cfa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input cmd_t in_data,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
	`CHK_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall || out_valid, "command taken but block not busy")
	`CHK_IMPLY(a_status_range, clk, arst_n, out_valid, out_data.status <= ST_NOT_LETTER, "status out of range")
	`CHK_IMPLY(a_start_zero, clk, arst_n, out_valid && out_data.status != ST_OK, out_data.start_index == 8'd0, "start index on failure")
endmodule

bind contiguous_fit_allocator_top cfa_port_checker u_chk (.*);

/* test/cfa_checker.sv */
// Checker for the contiguous fit allocator: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module cfa_checker
	import cfa_pkg::*;
#(
	parameter int MEM_CELLS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  cmd_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  rsp_t out_data,
	output int   fail_count,
	output int   pending_count
);
	logic [7:0] cells [MEM_CELLS];
	rsp_t       pending_rsp [$];

	function automatic bit letter_ok(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic rsp_t predict_rsp(input cmd_t c);
		rsp_t r;
		int   i, s, len, pick, pick_len, w;
		bit   found, take;
		r = '0;
		case (c.mode)
			MODE_ALLOC: begin
				if (!letter_ok(c.owner))
					r.status = ST_NOT_LETTER;
				else if (c.request_size == 0 || c.request_size > MEM_CELLS)
					r.status = ST_BAD_SIZE;
				else if (c.fit_policy > FIT_WORST)
					r.status = ST_NO_FIT;
				else begin
					found = 0;
					pick = 0;
					pick_len = 0;
					i = 0;
					while (i < MEM_CELLS) begin
						if (cells[i] == FREE_CELL) begin
							s = i;
							while (i < MEM_CELLS && cells[i] == FREE_CELL)
								i++;
							len = i - s;
							if (len >= c.request_size) begin
								if (!found)
									take = 1;
								else if (c.fit_policy == FIT_BEST)
									take = len < pick_len;
								else if (c.fit_policy == FIT_WORST)
									take = len > pick_len;
								else
									take = 0;
								if (take) begin
									pick = s;
									pick_len = len;
									found = 1;
								end
								if (found && c.fit_policy == FIT_FIRST)
									break;
							end
						end else
							i++;
					end
					if (!found)
						r.status = ST_NO_FIT;
					else begin
						for (i = pick; i < pick + c.request_size; i++)
							cells[i] = c.owner;
						r.start_index = pick[7:0];
					end
				end
			end
			MODE_FREE: begin
				if (!letter_ok(c.owner))
					r.status = ST_NOT_LETTER;
				else begin
					found = 0;
					for (i = 0; i < MEM_CELLS; i++)
						if (cells[i] == c.owner) begin
							cells[i] = FREE_CELL;
							found = 1;
						end
					r.status = found ? ST_OK : ST_NOT_FOUND;
				end
			end
			MODE_COMPACT: begin
				w = 0;
				for (i = 0; i < MEM_CELLS; i++)
					if (cells[i] != FREE_CELL) begin
						cells[w] = cells[i];
						w++;
					end
				for (i = w; i < MEM_CELLS; i++)
					cells[i] = FREE_CELL;
			end
			MODE_CLEAR: begin
				for (i = 0; i < MEM_CELLS; i++)
					cells[i] = FREE_CELL;
			end
			MODE_READ: begin
				if (c.cell_index < MEM_CELLS)
					r.read_owner = cells[c.cell_index];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending_count = pending_rsp.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_CELLS; i++)
				cells[i] = FREE_CELL;
			pending_rsp.delete();
			fail_count = 0;
		end else begin
			// The result is checked first; a command and its result never share an edge.
			if (out_valid && !out_stall) begin
				if (pending_rsp.size() == 0)
					report_mismatch("unexpected result", 1, 0);
				else begin
					want = pending_rsp.pop_front();
					if (out_data.status !== want.status)
						report_mismatch("status", out_data.status, want.status);
					if (out_data.start_index !== want.start_index)
						report_mismatch("start_index", out_data.start_index,
							want.start_index);
					if (out_data.read_owner !== want.read_owner)
						report_mismatch("read_owner", out_data.read_owner,
							want.read_owner);
				end
			end
			if (in_valid && !in_stall)
				pending_rsp.push_back(predict_rsp(in_data));
		end
	end
endmodule

/* test/tb_top.sv */
// Testbench top for the contiguous fit allocator: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
	import cfa_pkg::*;

	localparam int MEM_CELLS = 256;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int CMD_W = $bits(cmd_t);

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	cmd_t in_data;
	rsp_t out_data;
	int   fail_count, pending_count;
	int   cycle_count;
	bit   hold_out;
	bit   stim_done;

	contiguous_fit_allocator_top #(.MEM_CELLS(MEM_CELLS)) dut (.*);

	cfa_checker #(.MEM_CELLS(MEM_CELLS)) checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] pick_letter();
		return $urandom_range(1) ? 8'("A" + $urandom_range(5)) : 8'("a" + $urandom_range(2));
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(3);
		return $urandom_range(60, 10);
	endfunction

	// The valid line is dropped only when a gap follows, so each edge sees one assignment.
	task automatic send_cmd(input cmd_t c);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic cmd_t make_cmd(input logic [2:0] m, input logic [7:0] who,
		input logic [8:0] size, input logic [1:0] fit, input logic [7:0] idx);
		cmd_t c;
		c.mode = m;
		c.owner = who;
		c.request_size = size;
		c.fit_policy = fit;
		c.cell_index = idx;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		c = CMD_W'({$urandom, $urandom});
		r = $urandom_range(99);
		if (r < 45) begin
			c.mode = MODE_ALLOC;
			c.owner = pick_letter();
			c.fit_policy = 2'($urandom_range(2));
			case ($urandom_range(9))
				0: c.request_size = 9'($urandom_range(511));
				1: c.request_size = 9'($urandom_range(MEM_CELLS, 100));
				default: c.request_size = 9'($urandom_range(40, 1));
			endcase
		end else if (r < 65) begin
			c.mode = MODE_FREE;
			if ($urandom_range(9) != 0)
				c.owner = pick_letter();
		end else if (r < 88) begin
			c.mode = MODE_READ;
		end else if (r < 93)
			c.mode = MODE_COMPACT;
		else if (r < 95)
			c.mode = MODE_CLEAR;
		// The remainder keeps the fully random mode, unused ones included.
		return c;
	endfunction

	// Receiver stall: random gaps, and one long hold-off while commands keep coming.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out)
				out_stall <= 1'b1;
			else if ($urandom_range(9) < 3)
				out_stall <= 1'b1;
			else
				out_stall <= 1'b0;
		end
	end

	initial begin
		hold_out = 0;
		wait (stim_done == 0 && arst_n);
		repeat (30000) @(posedge clk);
		hold_out = 1;
		repeat (3000) @(posedge clk);
		hold_out = 0;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		stim_done = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: extremes, every mode and the rejection cases.
		send_cmd(make_cmd(MODE_READ, 8'h00, 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, 8'h40, 9'd4, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, 8'hff, 9'd4, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "A", 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "A", 9'd257, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "A", 9'd511, FIT_BEST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "z", 9'd256, FIT_WORST, 8'd0));
		send_cmd(make_cmd(MODE_READ, 8'h00, 9'd0, FIT_FIRST, 8'd255));
		send_cmd(make_cmd(MODE_ALLOC, "B", 9'd1, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_FREE, "z", 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "A", 9'd10, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "B", 9'd5, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "C", 9'd20, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_FREE, "A", 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "D", 9'd3, FIT_BEST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "E", 9'd3, FIT_WORST, 8'd0));
		send_cmd(make_cmd(MODE_ALLOC, "F", 9'd3, 2'd3, 8'd0));
		send_cmd(make_cmd(MODE_FREE, "Q", 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_FREE, 8'h5b, 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_COMPACT, 8'h00, 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_READ, 8'h00, 9'd0, FIT_FIRST, 8'd12));
		send_cmd(make_cmd(3'd7, 8'hff, 9'h1ff, 2'd3, 8'hff));
		send_cmd(make_cmd(MODE_CLEAR, 8'h00, 9'd0, FIT_FIRST, 8'd0));
		send_cmd(make_cmd(MODE_READ, 8'h00, 9'd0, FIT_FIRST, 8'd5));

		for (int n = 0; n < 700; n++)
			send_cmd(random_cmd());
		in_valid <= 1'b0;
		stim_done = 1;

		while (pending_count != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
